// ===== design/vn_pkg.sv =====
package vn_pkg;

	localparam int COMP_WIDTH = 16;
	localparam int FRAC_BITS  = 14;
	localparam int CFG_W      = 32;

	localparam int OUT_W   = FRAC_BITS + 2;
	localparam int N_W     = FRAC_BITS + 1;
	localparam int SQ_W    = 2 * COMP_WIDTH;
	localparam int S_W     = 2 * COMP_WIDTH;
	localparam int ACC_W   = 2 * FRAC_BITS + 4 + S_W;
	localparam int STAGES  = FRAC_BITS + 1;
	localparam int CMP_W   = (S_W > CFG_W) ? S_W : CFG_W;

	localparam int IN_TD_W  = ((3 * COMP_WIDTH + 7) / 8) * 8;
	localparam int OUT_TD_W = ((3 * OUT_W + 7) / 8) * 8;

	// one digit stage of a lane
	typedef struct packed {
		logic [N_W-1:0]   n;
		logic [ACC_W-1:0] u2;   // u^2 * s, u = 2n
		logic [ACC_W-1:0] us;   // u * s
		logic [S_W-1:0]   s;
		logic [ACC_W-1:0] r;    // a^2 << (2F+2)
	} lane_st_t;

endpackage

// ===== design/vn_lane.sv =====
module vn_lane (
	input  logic                  clk,
	input  logic                  en,
	input  logic [vn_pkg::S_W-1:0]   s_in,
	input  logic [vn_pkg::ACC_W-1:0] r_in,
	output logic [vn_pkg::N_W-1:0]   n_out
);
	import vn_pkg::*;

	lane_st_t st [STAGES+1];

	always_comb begin
		st[0].n  = '0;
		st[0].u2 = '0;
		st[0].us = '0;
		st[0].s  = s_in;
		st[0].r  = r_in;
	end

	// one result bit per stage, MSB first, no multiplier: u grows by 2^(k+1)
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam int K = FRAC_BITS - i;
		logic [ACC_W-1:0] s_w, u2t, ust, lhs;
		always_comb begin
			s_w = ACC_W'(st[i].s);
			u2t = st[i].u2 + (st[i].us << (K + 2)) + (s_w << (2 * K + 2));
			ust = st[i].us + (s_w << (K + 1));
			lhs = u2t - (ust << 1) + s_w;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st[i+1].s <= st[i].s;
				st[i+1].r <= st[i].r;
				if (lhs <= st[i].r) begin
					st[i+1].n  <= st[i].n | (N_W'(1) << K);
					st[i+1].u2 <= u2t;
					st[i+1].us <= ust;
				end else begin
					st[i+1].n  <= st[i].n;
					st[i+1].u2 <= st[i].u2;
					st[i+1].us <= st[i].us;
				end
			end
		end
	end

	assign n_out = st[STAGES].n;

endmodule

// ===== design/vector3_normalize_top.sv =====
// Three-component vector normalizer. Each item carries a signed vector
// (x, y, z); the result item carries round(c * 2^14 / |v|) for each
// component in Q1.14 (16384 = 1.0, ties away from zero), or the zero vector
// with the degenerate flag in tuser when x^2+y^2+z^2 <= min_length_sq.
// One item is accepted every cycle while the output is not stalled; the
// pipeline is a squares register, a sum register, one digit stage per result
// bit in each of the three component lanes and one output register. Any stall
// on the master side freezes the whole pipeline, so s_tready follows m_tready
// whenever the output register is full. The cfg channel is always ready.
module vector3_normalize_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// config write: min_length_sq
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [vn_pkg::CFG_W-1:0]     cfg_data,
	// slave: tdata = {pad, in_z, in_y, in_x}, in_x lowest
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [vn_pkg::IN_TD_W-1:0]   s_tdata,
	// master: tdata = {pad, out_z, out_y, out_x}, out_x lowest
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [vn_pkg::OUT_TD_W-1:0]  m_tdata,
	// master tuser = degenerate
	output logic                         m_tuser
);
	import vn_pkg::*;

	logic [CFG_W-1:0] min_q;
	logic             adv;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
		end else if (cfg_valid) begin
			min_q <= cfg_data;
		end
	end

	// whole pipeline moves when output register is free or being drained
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// front: magnitudes and squares
	logic [COMP_WIDTH-1:0] comp [3];
	logic [COMP_WIDTH-1:0] mag  [3];
	logic [2:0]            neg;
	logic [SQ_W-1:0]       sq_s1 [3];
	logic [2:0]            neg_s1;
	logic                  v_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			comp[i] = s_tdata[i*COMP_WIDTH +: COMP_WIDTH];
			neg[i]  = comp[i][COMP_WIDTH-1];
			mag[i]  = neg[i] ? (~comp[i] + COMP_WIDTH'(1)) : comp[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= SQ_W'(mag[i]) * SQ_W'(mag[i]);
			end
			neg_s1 <= neg;
		end
	end

	// sum, threshold, lane operands
	logic [S_W-1:0]   s_sum;
	logic [S_W-1:0]   s_s2;
	logic [ACC_W-1:0] r_s2 [3];
	logic [2:0]       neg_s2;
	logic             dg_s2;
	logic             v_s2;

	assign s_sum = sq_s1[0] + sq_s1[1] + sq_s1[2];

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s2   <= s_sum;
			dg_s2  <= CMP_W'(s_sum) <= CMP_W'(min_q);
			neg_s2 <= neg_s1;
			for (int i = 0; i < 3; i++) begin
				r_s2[i] <= ACC_W'(sq_s1[i]) << (2 * FRAC_BITS + 2);
			end
		end
	end

	// lanes: one per component
	logic [N_W-1:0] n_lane [3];
	for (genvar l = 0; l < 3; l++) begin : g_lane
		vn_lane u_lane (
			.clk    (clk),
			.en     (adv),
			.s_in   (s_s2),
			.r_in   (r_s2[l]),
			.n_out  (n_lane[l])
		);
	end

	// side band delay matching the lanes
	logic [2:0]  neg_d  [STAGES+1];
	logic        dg_d   [STAGES+1];
	logic        v_d    [STAGES+1];

	assign neg_d[0] = neg_s2;
	assign dg_d[0]  = dg_s2;
	assign v_d[0]   = v_s2;

	for (genvar i = 0; i < STAGES; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				neg_d[i+1] <= neg_d[i];
				dg_d[i+1]  <= dg_d[i];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[i+1] <= 1'b0;
			end else if (adv) begin
				v_d[i+1] <= v_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			v_s1     <= s_tvalid;
			v_s2     <= v_s1;
			m_tvalid <= v_d[STAGES];
		end
	end

	// merge: sign, degenerate override, pack
	logic [OUT_W-1:0] res [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dg_d[STAGES]) begin
				res[i] = '0;
			end else if (neg_d[STAGES][i]) begin
				res[i] = OUT_W'(0) - OUT_W'(n_lane[i]);
			end else begin
				res[i] = OUT_W'(n_lane[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= OUT_TD_W'({res[2], res[1], res[0]});
			m_tuser <= dg_d[STAGES];
		end
	end

endmodule

// ===== design/vn_checker.sv =====
module vn_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [vn_pkg::OUT_TD_W-1:0] m_tdata,
	input logic                        m_tuser
);
	import vn_pkg::*;

	// held result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped under stall");

	// degenerate result is the zero vector
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("degenerate item not zero");

	// a normalized vector is never all zero
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata != '0)
		else $error("normalized item is zero");

	// input only stalls under output backpressure
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without backpressure");

endmodule

bind vector3_normalize_top vn_checker u_vn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/vector3_normalize_checker.sv =====
module vector3_normalize_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [vn_pkg::CFG_W-1:0]     cfg_data,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [vn_pkg::IN_TD_W-1:0]   s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [vn_pkg::OUT_TD_W-1:0]  m_tdata,
	input  logic                         m_tuser,
	output int                           errors,
	output int                           pending
);
	import vn_pkg::*;

	typedef struct packed {
		logic [OUT_W-1:0] x;
		logic [OUT_W-1:0] y;
		logic [OUT_W-1:0] z;
		logic             degen;
	} unit_vec_t;

	unit_vec_t unit_q[$];
	logic [CFG_W-1:0] min_len_sq;

	// largest n with (2n-1)^2 * s <= 4 * a^2 * 4^F: round-half-away magnitude
	function automatic logic [N_W-1:0] scaled_mag(logic [63:0] a, logic [63:0] s);
		logic [127:0] rhs;
		logic [127:0] lhs;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] m;
		rhs = {64'd0, a * a} << (2 * FRAC_BITS + 2);
		lo = 0;
		hi = 64'd1 << FRAC_BITS;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			m = 2 * mid - 1;
			lhs = {64'd0, m * m} * {64'd0, s};
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return lo[N_W-1:0];
	endfunction

	function automatic unit_vec_t normalize(logic [IN_TD_W-1:0] td);
		unit_vec_t r;
		logic [63:0] mag[3];
		logic neg[3];
		logic [63:0] s;
		logic [COMP_WIDTH-1:0] c;
		logic [OUT_W-1:0] o[3];
		logic [N_W-1:0] n;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			c = td[i*COMP_WIDTH +: COMP_WIDTH];
			neg[i] = c[COMP_WIDTH-1];
			mag[i] = neg[i] ? (64'd1 << COMP_WIDTH) - c : c;
			s += mag[i] * mag[i];
		end
		if (s <= min_len_sq) begin
			r = '0;
			r.degen = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			n = scaled_mag(mag[i], s);
			o[i] = neg[i] ? -{1'b0, n} : {1'b0, n};
		end
		r.x = o[0];
		r.y = o[1];
		r.z = o[2];
		r.degen = 1'b0;
		return r;
	endfunction

	assign pending = unit_q.size();

	always @(posedge clk or negedge arst_n) begin
		unit_vec_t want;
		unit_vec_t got;
		if (!arst_n) begin
			min_len_sq <= '0;
			errors = 0;
			unit_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[0 +: OUT_W];
				got.y = m_tdata[OUT_W +: OUT_W];
				got.z = m_tdata[2*OUT_W +: OUT_W];
				got.degen = m_tuser;
				if (unit_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected item: x=%0d y=%0d z=%0d degen=%0b",
							$signed(got.x), $signed(got.y), $signed(got.z), got.degen);
				end else begin
					want = unit_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp x=%0d y=%0d z=%0d dg=%0b, got x=%0d y=%0d z=%0d dg=%0b",
								$signed(want.x), $signed(want.y), $signed(want.z), want.degen,
								$signed(got.x), $signed(got.y), $signed(got.z), got.degen);
					end
				end
			end
			if (s_tvalid && s_tready)
				unit_q.push_back(normalize(s_tdata));
			if (cfg_valid && cfg_ready)
				min_len_sq <= cfg_data;
		end
	end
endmodule

// ===== tb/vector3_normalize_top_test.sv =====
module vector3_normalize_top_test;
	import vn_pkg::*;

	localparam int LATENCY  = FRAC_BITS + 4;
	localparam int WATCHDOG = 20000;   // idle cycles without any handshake

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_TD_W-1:0]   s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_TD_W-1:0]  m_tdata;
	logic                 m_tuser;
	int                   errors;
	int                   pending;
	int                   idle_cycles;
	logic                 sink_run;

	vector3_normalize_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	vector3_normalize_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random back-pressure, switched off in some stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (!sink_run) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 9) < 7);
		end
	end

	// hang detector: nothing moving for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
			|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("FAIL vector3_normalize_top");
				$finish;
			end
		end
	end

	// valid stays high after the handshake so items can follow back to back
	task automatic send_vec(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tdata  <= IN_TD_W'({z, y, x});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_min(logic [CFG_W-1:0] v);
		drain();
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// random vector: full range, small values, or most-negative/near-zero picks
	task automatic send_random(bit gaps);
		logic [15:0] c[3];
		int k;
		k = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			if (k < 6) c[i] = $urandom();
			else if (k < 8) c[i] = $urandom_range(0, 15) - 8;
			else c[i] = ($urandom_range(0, 2) == 0) ? 16'h8000 : $urandom_range(0, 300) - 150;
		end
		send_vec(c[0], c[1], c[2], gaps);
	endtask

	logic [CFG_W-1:0] thresholds[5] = '{32'd0, 32'd1, 32'd200, 32'd1000000, 32'hC000_0000};

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		sink_run  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, single axes, most negative, extremes, ties region
		send_vec(16'd0, 16'd0, 16'd0, 0);
		send_vec(16'd1, 16'd0, 16'd0, 0);
		send_vec(16'd0, -16'sd1, 16'd0, 0);
		send_vec(16'd0, 16'd0, 16'h8000, 0);
		send_vec(16'h7FFF, 16'd0, 16'd0, 0);
		send_vec(16'h8000, 16'h8000, 16'h8000, 0);
		send_vec(16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
		send_vec(16'h8000, 16'h7FFF, 16'h8000, 0);
		send_vec(16'd1, 16'd1, 16'd1, 0);
		send_vec(16'd3, 16'd4, 16'd0, 0);
		send_vec(-16'sd2, 16'd3, -16'sd6, 0);
		send_vec(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
		send_vec(16'h5555, 16'hAAAA, 16'h0F0F, 0);
		send_vec(16'd1, 16'd2, 16'd2, 0);

		// threshold edges: S = 9 with minimum 8 and 9
		write_min(32'd9);
		send_vec(16'd3, 16'd0, 16'd0, 0);
		send_vec(16'd2, 16'd2, 16'd1, 0);
		send_vec(16'd2, 16'd2, 16'd2, 0);
		write_min(32'd8);
		send_vec(16'd0, 16'd3, 16'd0, 0);
		// all-ones threshold register, above the largest possible S
		write_min(32'hFFFF_FFFF);
		send_vec(16'h8000, 16'h8000, 16'h8000, 0);
		send_vec(16'h7FFF, 16'h7FFF, 16'd0, 0);
		write_min(32'hC000_0000);
		send_vec(16'h8000, 16'h8000, 16'h8000, 0);
		send_vec(16'h8000, 16'h8000, 16'h7FFF, 0);

		// random phases over several thresholds
		for (int ph = 0; ph < 5; ph++) begin
			write_min(thresholds[ph]);
			sink_run <= (ph != 2);
			for (int i = 0; i < 190; i++) begin
				send_random(ph != 3);
				// sender holds off until the pipeline has emptied
				if (ph == 1 && i == 95) drain();
			end
		end

		drain();
		if (errors == 0)
			$display("PASS vector3_normalize_top");
		else
			$display("FAIL vector3_normalize_top");
		$finish;
	end
endmodule

// ===== files.f =====
design/vn_pkg.sv
design/vn_lane.sv
design/vector3_normalize_top.sv
design/vn_checker.sv
tb/vector3_normalize_checker.sv
tb/vector3_normalize_top_test.sv
